>>> hw/rtl/ptt_pkg.sv
// shared constants for the point in triangle test pipeline
// no dependencies
`default_nettype none
package ptt_pkg;
	localparam int MUL_LIMB = 32;
	localparam int TOL_W = 16;
	localparam int KW = TOL_W + 1;
	localparam int K2_W = 2 * TOL_W + 1;
	localparam int SIDE_LAT = 15;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;
	localparam logic [KW-1:0] ONE_Q16 = 17'h10000;
	localparam logic [K2_W-1:0] K2_RESET = 33'd4294049841;
endpackage
`default_nettype wire

>>> hw/rtl/ptt_mul.sv
// pipelined unsigned multiplier built from limb partial products, three stages
// depends on ptt_pkg
`default_nettype none
module ptt_mul
	import ptt_pkg::*;
#(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic [AW+BW-1:0]   p
);
	localparam int LW = MUL_LIMB;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int RW = (NB + 1) * LW;
	localparam int TW = (NA + NB) * LW;

	logic [NA*LW-1:0] ap;
	logic [NB*LW-1:0] bp;
	logic [2*LW-1:0] pp_s1 [NA][NB];
	logic [RW-1:0] row_c [NA];
	logic [RW-1:0] row_s2 [NA];
	logic [TW-1:0] sum_c;
	logic [TW-1:0] p_s3;

	assign ap = (NA*LW)'(a);
	assign bp = (NB*LW)'(b);

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= (2*LW)'(ap[i*LW +: LW]) * (2*LW)'(bp[j*LW +: LW]);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s1[i][j]) << (j*LW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_c;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (TW'(row_s2[i]) << (i*LW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= sum_c;
		end
	end

	assign p = p_s3[AW+BW-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/ptt_side.sv
// angle test at one vertex: normals, dot and norms, root-free cosine compare
// depends on ptt_pkg and ptt_mul
`default_nettype none
module ptt_side
	import ptt_pkg::*;
#(
	parameter int N = 16
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [3*N-1:0]    org,
	input  wire logic [3*N-1:0]    eu,
	input  wire logic [3*N-1:0]    ev,
	input  wire logic [3*N-1:0]    pt,
	input  wire logic [K2_W-1:0]   k2,
	output logic                   in_angle
);
	localparam int DW = N + 1;
	localparam int CW = 2 * DW;
	localparam int NW = CW + 1;
	localparam int MW = NW - 1;
	localparam int PW = 2 * MW + 2;
	localparam int SW = 2 * MW + 3;
	localparam int CMPW = 2 * PW + K2_W;

	logic signed [DW-1:0] u_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [CW-1:0] na0_s2 [3];
	logic signed [CW-1:0] na1_s2 [3];
	logic signed [CW-1:0] nb0_s2 [3];
	logic signed [CW-1:0] nb1_s2 [3];
	logic signed [NW-1:0] na_s3 [3];
	logic signed [NW-1:0] nb_s3 [3];
	logic [MW-1:0] ma_s4 [3];
	logic [MW-1:0] mb_s4 [3];
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7;
	logic zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;
	logic [2*MW-1:0] dp [3];
	logic [2*MW-1:0] qa [3];
	logic [2*MW-1:0] qb [3];
	logic signed [SW-1:0] dot_c;
	logic [PW-1:0] sa_c, sb_c;
	logic signed [SW-1:0] dot_s8;
	logic [PW-1:0] sa_s8, sb_s8;
	logic dpos;
	logic [1:0] flags_s9to14 [6];
	logic [2*PW-1:0] lhs, sab;
	logic [2*PW-1:0] lhs_s12to14 [3];
	logic [2*PW+K2_W-1:0] rhs;
	logic in_angle_s15;

	genvar k;
	for (k = 0; k < 3; k++) begin : g_axis
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		always_ff @(posedge clk) begin
			if (en) begin
				u_s1[k] <= DW'($signed(eu[k*N +: N])) - DW'($signed(org[k*N +: N]));
				v_s1[k] <= DW'($signed(ev[k*N +: N])) - DW'($signed(org[k*N +: N]));
				d_s1[k] <= DW'($signed(pt[k*N +: N])) - DW'($signed(org[k*N +: N]));
				// na = u x d, nb = d x v
				na0_s2[k] <= u_s1[K1] * d_s1[K2];
				na1_s2[k] <= u_s1[K2] * d_s1[K1];
				nb0_s2[k] <= d_s1[K1] * v_s1[K2];
				nb1_s2[k] <= d_s1[K2] * v_s1[K1];
				na_s3[k] <= NW'(na0_s2[k]) - NW'(na1_s2[k]);
				nb_s3[k] <= NW'(nb0_s2[k]) - NW'(nb1_s2[k]);
				ma_s4[k] <= na_s3[k][NW-1] ? MW'(-na_s3[k]) : MW'(na_s3[k]);
				mb_s4[k] <= nb_s3[k][NW-1] ? MW'(-nb_s3[k]) : MW'(nb_s3[k]);
				neg_s4[k] <= na_s3[k][NW-1] ^ nb_s3[k][NW-1];
			end
		end

		ptt_mul #(.AW(MW), .BW(MW)) u_dot (
			.clk(clk), .en(en), .a(ma_s4[k]), .b(mb_s4[k]), .p(dp[k]));
		ptt_mul #(.AW(MW), .BW(MW)) u_sqa (
			.clk(clk), .en(en), .a(ma_s4[k]), .b(ma_s4[k]), .p(qa[k]));
		ptt_mul #(.AW(MW), .BW(MW)) u_sqb (
			.clk(clk), .en(en), .a(mb_s4[k]), .b(mb_s4[k]), .p(qb[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= (na_s3[0] == '0 && na_s3[1] == '0 && na_s3[2] == '0) ||
				(nb_s3[0] == '0 && nb_s3[1] == '0 && nb_s3[2] == '0);
			zero_s5 <= zero_s4;
			zero_s6 <= zero_s5;
			zero_s7 <= zero_s6;
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			neg_s7 <= neg_s6;
		end
	end

	// signed dot product and both squared norms
	always_comb begin
		dot_c = '0;
		sa_c = '0;
		sb_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (neg_s7[i]) begin
				dot_c = dot_c - $signed({3'b000, dp[i]});
			end else begin
				dot_c = dot_c + $signed({3'b000, dp[i]});
			end
			sa_c = sa_c + PW'(qa[i]);
			sb_c = sb_c + PW'(qb[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s8 <= dot_c;
			sa_s8 <= sa_c;
			sb_s8 <= sb_c;
			zero_s8 <= zero_s7;
		end
	end

	assign dpos = (dot_s8 > 0);

	ptt_mul #(.AW(PW), .BW(PW)) u_lhs (
		.clk(clk), .en(en), .a(dot_s8[PW-1:0]), .b(dot_s8[PW-1:0]), .p(lhs));
	ptt_mul #(.AW(PW), .BW(PW)) u_sab (
		.clk(clk), .en(en), .a(sa_s8), .b(sb_s8), .p(sab));
	ptt_mul #(.AW(2*PW), .BW(K2_W)) u_rhs (
		.clk(clk), .en(en), .a(sab), .b(k2), .p(rhs));

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s9to14[0] <= {zero_s8, dpos};
			for (int i = 1; i < 6; i++) begin
				flags_s9to14[i] <= flags_s9to14[i-1];
			end
			lhs_s12to14[0] <= lhs;
			lhs_s12to14[1] <= lhs_s12to14[0];
			lhs_s12to14[2] <= lhs_s12to14[1];
			in_angle_s15 <= flags_s9to14[5][1] || (flags_s9to14[5][0] &&
				((CMPW'(lhs_s12to14[2]) << 32) >= CMPW'(rhs)));
		end
	end

	assign in_angle = in_angle_s15;
endmodule
`default_nettype wire

>>> hw/rtl/point_in_triangle_test.sv
// top level: stream ports, tolerance register, two vertex angle tests
// depends on ptt_pkg, ptt_side, ptt_mul
`default_nettype none
// channel  | signals                      | payload
// ---------+------------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata    | vertex a, b, c and query xyz, coords
// output   | m_tvalid m_tready m_tdata    | inside_res in bit 0
// config   | cfg_valid cfg_ready cfg_data | tolerance, unsigned q0.16
//
// one request enters per cycle unless a finished result is waiting at the output
// the pipeline depth is set by the multiplier chain: normals, dot and norms, squares,
// then the tolerance product, each wide multiply three stages deep
// the whole pipeline advances together; it holds while the output waits
// reset clears valid bits and reloads the tolerance of 7, no clearing pass
module point_in_triangle_test
	import ptt_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z from bit 0 up
	input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// inside_res in bit 0, rest zero
	output logic [7:0] m_tdata,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [TOL_W-1:0] cfg_data
);
	localparam int N = COORD_BITS;
	localparam int TOT = SIDE_LAT + 1;

	logic en;
	logic [TOT-1:0] vld_q;
	logic [TOL_W-1:0] tol_q;
	logic [K2_W-1:0] k2_q;
	logic [KW-1:0] k;
	logic [2*KW-1:0] kk;
	logic at_a, at_b;
	logic res_s16;

	// advance unless the finished result is still waiting
	assign en = !vld_q[TOT-1] || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// (1 - tol)^2 scaled by 2^32, kept in a register
	assign k = ONE_Q16 - KW'(tol_q);
	assign kk = (2*KW)'(k) * (2*KW)'(k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			k2_q <= K2_RESET;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			k2_q <= kk[K2_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], s_tvalid};
		end
	end

	// at vertex a: u = b-a, v = c-a, d = p-a
	ptt_side #(.N(N)) u_side_a (
		.clk(clk), .en(en),
		.org(s_tdata[3*N-1:0]), .eu(s_tdata[6*N-1:3*N]),
		.ev(s_tdata[9*N-1:6*N]), .pt(s_tdata[12*N-1:9*N]),
		.k2(k2_q), .in_angle(at_a));

	// at vertex b: u = a-b, v = c-b, d = p-b
	ptt_side #(.N(N)) u_side_b (
		.clk(clk), .en(en),
		.org(s_tdata[6*N-1:3*N]), .eu(s_tdata[3*N-1:0]),
		.ev(s_tdata[9*N-1:6*N]), .pt(s_tdata[12*N-1:9*N]),
		.k2(k2_q), .in_angle(at_b));

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s16 <= at_a && at_b;
		end
	end

	assign m_tvalid = vld_q[TOT-1];
	assign m_tdata = {7'b0000000, res_s16};

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !(m_tvalid && !m_tready))
		else $error("request accepted while pipeline stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted request lost at first stage");

	a_k2_tracks_tol: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (k2_q == $past(kk[K2_W-1:0])))
		else $error("tolerance square out of step");
endmodule
`default_nettype wire
